FILE: rtl/core/a256cm_pkg.sv
package a256cm_pkg;

  typedef struct packed {
    logic [63:0] block_hi;
    logic [63:0] block_lo;
    logic [4:0]  valid_bytes;
    logic        last_block;
    logic [63:0] expected_hi;
    logic [63:0] expected_lo;
  } in_item_t;

  typedef struct packed {
    logic [63:0] tag_hi;
    logic [63:0] tag_lo;
    logic        tag_match;
  } out_item_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_KEY0 = 2'd0;
  localparam logic [1:0] REG_KEY1 = 2'd1;
  localparam logic [1:0] REG_KEY2 = 2'd2;
  localparam logic [1:0] REG_KEY3 = 2'd3;

  localparam logic [7:0] RB_CONST = 8'h87;
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [3:0] LAST_ROUND = 4'd14;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_LOAD_ZERO,
    CMD_LOAD_MSG,
    CMD_ROUND,
    CMD_SAVE_SUBKEY,
    CMD_SAVE_CHAIN,
    CMD_SAVE_TAG
  } dp_cmd_e;

  typedef struct packed {
    dp_cmd_e    op;
    logic [3:0] round;
  } dp_ctrl_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  // Multiplication by x in GF(2^128).
  function automatic logic [127:0] gf_double(input logic [127:0] v);
    return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RB_CONST : 8'h00)};
  endfunction

  // One AES round on a big-endian state: SubBytes, ShiftRows, and MixColumns when mix is set.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic mix);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 16; i++) begin
      b[i] = SBOX[s[127-8*i -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        t[k + 4*c] = b[k + 4*((c + k) % 4)];
      end
    end
    if (mix) begin
      for (int c = 0; c < 4; c++) begin
        a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        t[4*c]   = a0 ^ al ^ xtime(a0 ^ a1);
        t[4*c+1] = a1 ^ al ^ xtime(a1 ^ a2);
        t[4*c+2] = a2 ^ al ^ xtime(a2 ^ a3);
        t[4*c+3] = a3 ^ al ^ xtime(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = t[i];
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/a256cm_ctrl.sv
module a256cm_ctrl
  import a256cm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_ctrl_t ctrl
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUBKEY, ST_LOAD, ST_MSG, ST_RESULT
  } state_e;

  state_e     state_r;
  logic [3:0] round_r;
  logic       mid_r;
  logic       last_r;
  logic       out_valid_r;

  // A new request is taken in idle once the previous tag has been taken.
  assign in_ready  = (state_r == ST_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;

  always_comb begin
    ctrl.op    = CMD_IDLE;
    ctrl.round = round_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          ctrl.op = mid_r ? CMD_LOAD_MSG : CMD_LOAD_ZERO;
        end
      end
      ST_SUBKEY: begin
        ctrl.op = (round_r == LAST_ROUND + 4'd1) ? CMD_SAVE_SUBKEY : CMD_ROUND;
      end
      ST_LOAD: ctrl.op = CMD_LOAD_MSG;
      ST_MSG: begin
        if (round_r == LAST_ROUND + 4'd1) begin
          ctrl.op = last_r ? CMD_SAVE_TAG : CMD_SAVE_CHAIN;
        end else begin
          ctrl.op = CMD_ROUND;
        end
      end
      ST_RESULT: ctrl.op = CMD_IDLE;
      default:   ctrl.op = CMD_IDLE;
    endcase
  end

  // Sequencer: optional subkey pass, then fourteen rounds for the block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      round_r     <= 4'd0;
      mid_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_valid && in_ready) begin
            last_r  <= in_last;
            round_r <= 4'd1;
            state_r <= mid_r ? ST_MSG : ST_SUBKEY;
          end
        end
        ST_SUBKEY: begin
          if (round_r == LAST_ROUND + 4'd1) begin
            mid_r   <= 1'b1;
            state_r <= ST_LOAD;
          end else begin
            round_r <= round_r + 4'd1;
          end
        end
        ST_LOAD: begin
          round_r <= 4'd1;
          state_r <= ST_MSG;
        end
        ST_MSG: begin
          if (round_r == LAST_ROUND + 4'd1) begin
            if (last_r) begin
              mid_r       <= 1'b0;
              out_valid_r <= 1'b1;
              state_r     <= ST_RESULT;
            end else begin
              state_r <= ST_IDLE;
            end
          end else begin
            round_r <= round_r + 4'd1;
          end
        end
        ST_RESULT: state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  // The subkey pass only follows a request that opens a message.
  a_subkey_first: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !mid_r) |=> (state_r == ST_SUBKEY))
    else $error("subkey pass not started");
  // No request is taken while the engine works.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_ready)
    else $error("request taken while busy");
  // A tag appears only at the end of a last block.
  a_tag: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (state_r == ST_RESULT) && last_r)
    else $error("unexpected tag");

endmodule

FILE: rtl/core/a256cm_datapath.sv
module a256cm_datapath
  import a256cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [1:0] cfg_sel,
  input  logic [63:0] cfg_data,
  input  logic      in_take,
  input  in_item_t  in_item,
  input  dp_ctrl_t  ctrl,
  output out_item_t result
);

  logic [63:0]  key_r [4];
  logic [127:0] state_r;
  logic [127:0] chain_r;
  logic [127:0] k1_r;
  logic [127:0] msg_r;
  logic [127:0] exp_r;
  logic [4:0]   nbytes_r;
  logic         last_r;
  // Key schedule runs alongside the rounds: rk_a/rk_b are the current pair.
  logic [127:0] rk_a_r, rk_b_r;
  logic [7:0]   rcon_r;
  out_item_t    result_r;

  logic [127:0] msg_pad, last_key, block_in, round_out;
  logic [255:0] key_full;
  logic [127:0] next_b;
  logic [31:0]  t0, t1, t2, t3, u;
  logic [4:0]   n;
  logic [127:0] msg_cur;
  logic [4:0]   nbytes_cur;
  logic         last_cur;

  assign key_full = {key_r[0], key_r[1], key_r[2], key_r[3]};
  assign result   = result_r;

  // A block loaded in the cycle it is accepted comes straight from the input.
  assign msg_cur    = in_take ? {in_item.block_hi, in_item.block_lo} : msg_r;
  assign nbytes_cur = in_take ? in_item.valid_bytes : nbytes_r;
  assign last_cur   = in_take ? in_item.last_block : last_r;

  // Padding and subkey choice for the last block; every block is XORed with the chain value.
  always_comb begin
    n = (nbytes_cur > 5'd16) ? 5'd16 : nbytes_cur;
    msg_pad = msg_cur;
    for (int j = 0; j < 16; j++) begin
      if (5'(j) >= n) begin
        msg_pad[127-8*j -: 8] = (5'(j) == n) ? PAD_MARK : 8'h00;
      end
    end
    last_key = (n == 5'd16) ? k1_r : gf_double(k1_r);
    if (!last_cur) begin
      block_in = msg_cur ^ chain_r;
    end else begin
      block_in = msg_pad ^ last_key ^ chain_r;
    end
  end

  // Next 128 bits of the AES-256 key schedule from the current pair.
  always_comb begin
    u  = sub_word({rk_b_r[23:0], rk_b_r[31:24]}) ^ {rcon_r, 24'd0};
    t0 = rk_a_r[127:96] ^ u;
    t1 = rk_a_r[95:64] ^ t0;
    t2 = rk_a_r[63:32] ^ t1;
    t3 = rk_a_r[31:0] ^ t2;
    // Even rounds use the plain SubWord step instead.
    if (ctrl.round[0]) begin
      next_b = {t0, t1, t2, t3};
    end else begin
      u      = sub_word(rk_b_r[31:0]);
      t0     = rk_a_r[127:96] ^ u;
      t1     = rk_a_r[95:64] ^ t0;
      t2     = rk_a_r[63:32] ^ t1;
      t3     = rk_a_r[31:0] ^ t2;
      next_b = {t0, t1, t2, t3};
    end
    round_out = aes_round(state_r, ctrl.round != LAST_ROUND) ^ rk_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= 64'd0;
      chain_r <= '0;
    end else begin
      if (cfg_we) begin
        key_r[cfg_sel] <= cfg_data;
      end
      unique case (ctrl.op)
        CMD_LOAD_ZERO, CMD_LOAD_MSG: begin
          state_r <= ((ctrl.op == CMD_LOAD_ZERO) ? 128'd0 : block_in) ^ key_full[255:128];
          rk_a_r  <= key_full[255:128];
          rk_b_r  <= key_full[127:0];
          rcon_r  <= 8'h01;
          if (ctrl.op == CMD_LOAD_ZERO) chain_r <= '0;
        end
        CMD_ROUND: begin
          // rk_b holds the key for this round; advance the pair.
          state_r <= round_out;
          rk_a_r  <= rk_b_r;
          rk_b_r  <= next_b;
          if (ctrl.round[0]) rcon_r <= xtime(rcon_r);
        end
        CMD_SAVE_SUBKEY: k1_r <= gf_double(state_r);
        CMD_SAVE_CHAIN:  chain_r <= state_r;
        CMD_SAVE_TAG: begin
          chain_r            <= '0;
          result_r.tag_hi    <= state_r[127:64];
          result_r.tag_lo    <= state_r[63:0];
          result_r.tag_match <= ~|(state_r ^ exp_r);
        end
        CMD_IDLE: ;
        default: ;
      endcase
      if (in_take) begin
        msg_r    <= {in_item.block_hi, in_item.block_lo};
        exp_r    <= {in_item.expected_hi, in_item.expected_lo};
        nbytes_r <= in_item.valid_bytes;
        last_r   <= in_item.last_block;
      end
    end
  end

  // After a subkey save the chain is clear for the new message.
  a_chain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == CMD_SAVE_SUBKEY) |-> (chain_r == 128'd0))
    else $error("chain not cleared");
  // A tag save always clears the chain.
  a_tag_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == CMD_SAVE_TAG) |=> (chain_r == 128'd0))
    else $error("chain kept after tag");
  // Round commands carry round numbers one to fourteen.
  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == CMD_ROUND) |-> (ctrl.round != 4'd0) && (ctrl.round <= LAST_ROUND))
    else $error("round out of range");

endmodule

FILE: rtl/core/aes256_cmac_engine.sv
// Channel  | Valid / ready          | Payload
// input    | in_valid / in_ready    | in_data (in_item_t)
// result   | out_valid / out_ready  | out_data (out_item_t)
// config   | cfg_valid / cfg_ready  | cfg_index, cfg_data
// A block runs one load, fourteen rounds of the shared round unit and one save;
// the first block of a message adds the subkey pass and a reload before it.
// A last block then hands its tag over in a result state before the next request.
// The result register holds one tag; the next request waits until it is taken.
// Reset is synchronous and clears the key, chain value and message state.
// Configuration writes are taken in every cycle.
module aes256_cmac_engine
  import a256cm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [63:0] cfg_data
);

  dp_ctrl_t ctrl;

  assign cfg_ready = 1'b1;

  a256cm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_last   (in_data.last_block),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .ctrl      (ctrl)
  );

  a256cm_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_sel  (cfg_index),
    .cfg_data (cfg_data),
    .in_take  (in_valid && in_ready),
    .in_item  (in_data),
    .ctrl     (ctrl),
    .result   (out_data)
  );

endmodule

FILE: dv/aes256_cmac_engine_test.sv
module aes256_cmac_engine_test
  import a256cm_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int SETTLE_CYCLES = 80;
  localparam int RANDOM_ITEMS = 1250;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [63:0] cfg_data;

  aes256_cmac_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Predictor state: key registers, chaining value, subkey and message flag.
  logic [63:0]  key_regs [4];
  logic [127:0] cbc_state;
  logic [127:0] k1_subkey;
  logic         in_message;

  out_item_t tag_queue [$];
  int        mismatches;
  int        cycle_count;
  logic      quiet_sender;
  logic      quiet_sink;

  // AES S-box, kept local so that the predictor is independent of the design.
  localparam logic [7:0] SB [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] times_x(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [127:0] double_block(input logic [127:0] v);
    logic [127:0] r;
    r = v << 1;
    if (v[127]) begin
      r[7:0] = r[7:0] ^ 8'h87;
    end
    return r;
  endfunction

  // AES-256 encryption under the current key registers, state held big-endian.
  function automatic logic [127:0] aes256_block(input logic [127:0] pt);
    logic [31:0] w [60];
    logic [31:0] x;
    logic [7:0]  rcon;
    logic [7:0]  s [16];
    logic [7:0]  t [16];
    logic [7:0]  a0, a1, a2, a3, al;
    logic [127:0] r;
    for (int i = 0; i < 8; i++) begin
      w[i] = (i % 2 == 0) ? key_regs[i/2][63:32] : key_regs[i/2][31:0];
    end
    rcon = 8'h01;
    for (int i = 8; i < 60; i++) begin
      x = w[i-1];
      if (i % 8 == 0) begin
        x = {x[23:0], x[31:24]};
        x = {SB[x[31:24]] ^ rcon, SB[x[23:16]], SB[x[15:8]], SB[x[7:0]]};
        rcon = times_x(rcon);
      end else if (i % 8 == 4) begin
        x = {SB[x[31:24]], SB[x[23:16]], SB[x[15:8]], SB[x[7:0]]};
      end
      w[i] = w[i-8] ^ x;
    end
    for (int i = 0; i < 16; i++) begin
      s[i] = pt[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
    end
    for (int rnd = 1; rnd <= 14; rnd++) begin
      for (int c = 0; c < 4; c++) begin
        for (int k = 0; k < 4; k++) begin
          t[k+4*c] = SB[s[k+4*((c+k)%4)]];
        end
      end
      if (rnd != 14) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ times_x(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ times_x(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ times_x(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ times_x(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) begin
        s[i] = t[i] ^ w[4*rnd + i/4][31-8*(i%4) -: 8];
      end
    end
    for (int i = 0; i < 16; i++) begin
      r[127-8*i -: 8] = s[i];
    end
    return r;
  endfunction

  // Advances the CMAC state by one request; a last block yields a tag.
  function automatic void cmac_absorb(input in_item_t rq);
    logic [127:0] blk;
    logic [127:0] sk;
    logic [127:0] tg;
    int           n;
    out_item_t    o;
    if (!in_message) begin
      k1_subkey = double_block(aes256_block(128'd0));
      cbc_state = '0;
      in_message = 1'b1;
    end
    blk = {rq.block_hi, rq.block_lo};
    if (!rq.last_block) begin
      cbc_state = aes256_block(blk ^ cbc_state);
    end else begin
      n = (rq.valid_bytes > 16) ? 16 : int'(rq.valid_bytes);
      sk = k1_subkey;
      if (n < 16) begin
        sk = double_block(sk);
        for (int j = n; j < 16; j++) begin
          blk[127-8*j -: 8] = 8'h00;
        end
        blk[127-8*n -: 8] = 8'h80;
      end
      tg = aes256_block(blk ^ sk ^ cbc_state);
      o.tag_hi = tg[127:64];
      o.tag_lo = tg[63:0];
      o.tag_match = (tg == {rq.expected_hi, rq.expected_lo});
      tag_queue.push_back(o);
      cbc_state = '0;
      in_message = 1'b0;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result sink: compares every tag with the oldest prediction.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= quiet_sink ? 1'b1 : ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (tag_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tag %h %h", out_data.tag_hi, out_data.tag_lo);
      end else begin
        if (out_data.tag_hi !== tag_queue[0].tag_hi || out_data.tag_lo !== tag_queue[0].tag_lo
            || out_data.tag_match !== tag_queue[0].tag_match) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tag mismatch: expected %h %h %b, got %h %h %b",
                     tag_queue[0].tag_hi, tag_queue[0].tag_lo, tag_queue[0].tag_match,
                     out_data.tag_hi, out_data.tag_lo, out_data.tag_match);
          end
        end
        void'(tag_queue.pop_front());
      end
    end
  end

  task automatic write_key(input logic [1:0] idx, input logic [63:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    key_regs[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_key(input logic [63:0] k0, k1, k2, k3);
    write_key(REG_KEY0, k0);
    write_key(REG_KEY1, k1);
    write_key(REG_KEY2, k2);
    write_key(REG_KEY3, k3);
  endtask

  // Offers one request, with a random gap first unless the sender is held busy.
  task automatic send_block(input in_item_t rq);
    @(negedge clk);
    while (!quiet_sender && $urandom_range(99) < 32) @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= rq;
    do @(posedge clk); while (!in_ready);
    cmac_absorb(rq);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain_tags();
    while (tag_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_item_t random_block(input logic is_last);
    in_item_t r;
    r.block_hi = {$urandom, $urandom};
    r.block_lo = {$urandom, $urandom};
    r.valid_bytes = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(16));
    r.last_block = is_last;
    r.expected_hi = {$urandom, $urandom};
    r.expected_lo = {$urandom, $urandom};
    return r;
  endfunction

  // Directed stimulus: rows under a key of zeros, then random rows under a key of all ones.
  in_item_t directed_rows [20];

  initial begin
    int       msg_len;
    int       sent;
    in_item_t rq;
    logic [127:0] tmp;
    mismatches = 0;
    quiet_sender = 1'b0;
    quiet_sink = 1'b0;
    in_message = 1'b0;
    cbc_state = '0;
    k1_subkey = '0;
    for (int i = 0; i < 4; i++) key_regs[i] = '0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_KEY0;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Table: empty message, extremes, oversize length, short and long messages.
    directed_rows[0]  = '{64'd0, 64'd0, 5'd0, 1'b1, 64'd0, 64'd0};
    directed_rows[1]  = '{'1, '1, 5'd16, 1'b1, '1, '1};
    directed_rows[2]  = '{'1, '1, 5'd31, 1'b1, 64'd0, 64'd0};
    directed_rows[3]  = '{'1, '1, 5'd1, 1'b1, '1, 64'd0};
    directed_rows[4]  = '{64'h0123456789abcdef, 64'hfedcba9876543210, 5'd15, 1'b1, 0, 0};
    directed_rows[5]  = '{'1, '1, 5'd0, 1'b0, '1, '1};
    directed_rows[6]  = '{64'd0, 64'd0, 5'd16, 1'b1, 0, 0};
    directed_rows[7]  = '{'1, 64'd0, 5'd3, 1'b0, 0, 0};
    directed_rows[8]  = '{64'd0, '1, 5'd31, 1'b0, 0, 0};
    directed_rows[9]  = '{64'h8000000000000000, 64'd1, 5'd8, 1'b1, 0, 0};
    directed_rows[10] = '{64'd0, 64'd0, 5'd17, 1'b1, 0, 0};
    directed_rows[11] = '{'1, '1, 5'd0, 1'b1, 0, 0};
    directed_rows[12] = '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd16, 1'b0, 0, 0};
    directed_rows[13] = '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd7, 1'b1, 0, 0};
    for (int i = 0; i < 14; i++) send_block(directed_rows[i]);
    drain_tags();

    // A known tag fed back as the expected value must report a match.
    rq = '{64'h1111, 64'h2222, 5'd16, 1'b1, 0, 0};
    in_message = 1'b0;
    tmp = double_block(aes256_block(128'd0));
    tmp = aes256_block({rq.block_hi, rq.block_lo} ^ tmp);
    rq.expected_hi = tmp[127:64];
    rq.expected_lo = tmp[63:0];
    send_block(rq);
    drain_tags();

    // Key of all ones, then random rows under it.
    load_key('1, '1, '1, '1);
    for (int i = 15; i < 20; i++) directed_rows[i] = random_block(i != 17 && i != 19);
    directed_rows[17].last_block = 1'b0;
    for (int i = 15; i < 20; i++) send_block(directed_rows[i]);
    drain_tags();

    // Random messages under several keys; one phase with no idling at all.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      load_key({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
               {$urandom, $urandom});
      quiet_sender = (ph == 2);
      quiet_sink = (ph == 2);
      while (sent < (ph + 1) * RANDOM_ITEMS / 6) begin
        msg_len = ($urandom_range(9) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 4);
        for (int m = 0; m < msg_len; m++) begin
          send_block(random_block(m == msg_len - 1));
          sent++;
        end
        // When sent % 97 is below four, hold the sender until every tag has come back.
        if (sent % 97 < 4) begin
          while (tag_queue.size() != 0) @(posedge clk);
        end
      end
      quiet_sender = 1'b0;
      quiet_sink = 1'b0;
      drain_tags();
    end

    // A key change in the middle of a message.
    send_block(random_block(1'b0));
    drain_tags();
    write_key(REG_KEY2, 64'd0);
    send_block(random_block(1'b1));
    drain_tags();

    if (mismatches == 0 && tag_queue.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
